### rtl/wasd_pkg.sv
// shared types, constants and register indexes for the window average block
`timescale 1ns / 1ps

package wasd_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int SUM_WIDTH    = 24;
   localparam int COUNT_WIDTH  = 8;
   localparam int MEAN_WIDTH   = 20;
   localparam int CHANGE_WIDTH = 21;
   localparam int LEVEL_WIDTH  = 13;
   localparam int FS_WIDTH     = 19;
   localparam int THR_WIDTH    = 20;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 20;

   localparam int DIV_WIDTH      = 31;
   localparam int DIV_REM_WIDTH  = FS_WIDTH;
   localparam int DIV_CNT_WIDTH  = 5;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST_STEP = DIV_CNT_WIDTH'(DIV_WIDTH - 1);

   localparam logic [COUNT_WIDTH-1:0] MAX_WINDOW = 8'd255;

   localparam logic [SAMPLE_WIDTH-1:0] FAILED_READ   = 16'h8000;
   localparam logic [LEVEL_WIDTH-1:0]  LEVEL_FULL    = 13'd4096;
   localparam logic [MEAN_WIDTH-1:0]   MEAN_SENTINEL = -20'sd16;

   localparam logic [COUNT_WIDTH-1:0] WINDOW_LENGTH_RESET = 8'd10;
   localparam logic [FS_WIDTH-1:0]    FULL_SCALE_RESET    = 19'd32752;
   localparam logic [THR_WIDTH-1:0]   THRESHOLD_RESET     = 20'd32;
   localparam logic [COUNT_WIDTH-1:0] CONFIRM_RESET       = 8'd5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LENGTH    = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FULL_SCALE       = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTLE_THRESHOLD = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTLE_CONFIRM   = 8'd3;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MEAN_START,
      ST_MEAN_RUN,
      ST_LEVEL_START,
      ST_LEVEL_RUN,
      ST_RESULT
   } wasd_state_type;

   typedef struct packed {
      logic accept;
      logic mean_start;
      logic mean_latch;
      logic change_latch;
      logic level_start;
      logic level_zero;
      logic level_latch;
      logic write_result;
   } wasd_cmd_type;

   typedef struct packed {
      logic last;
      logic good_zero;
      logic mean_nonpos;
      logic div_done;
      logic out_free;
   } wasd_status_type;

endpackage

### rtl/wasd_divider.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wasd_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wasd_pkg::DIV_WIDTH-1:0]      dividend,
   input  logic [wasd_pkg::DIV_REM_WIDTH-1:0]  divisor,
   output logic                                busy,
   output logic                                done,
   output logic [wasd_pkg::DIV_WIDTH-1:0]      quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [wasd_pkg::DIV_CNT_WIDTH-1:0]  count_ff, count_in;
   logic [wasd_pkg::DIV_WIDTH-1:0]      q_ff, q_in;
   logic [wasd_pkg::DIV_REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [wasd_pkg::DIV_REM_WIDTH-1:0]  div_ff, div_in;
   logic [wasd_pkg::DIV_REM_WIDTH:0]    trial;
   logic [wasd_pkg::DIV_REM_WIDTH:0]    diff;
   logic                                ge;

   assign trial = {rem_ff, q_ff[wasd_pkg::DIV_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         q_in     = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         q_in     = {q_ff[wasd_pkg::DIV_WIDTH-2:0], ge};
         rem_in   = ge ? diff[wasd_pkg::DIV_REM_WIDTH-1:0]
                       : trial[wasd_pkg::DIV_REM_WIDTH-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == wasd_pkg::DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### rtl/wasd_datapath.sv
// accumulators, history, settings, divider operands and result register
`timescale 1ns / 1ps

module wasd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [wasd_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                   csr_write,
   input  logic [wasd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [wasd_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  wasd_pkg::wasd_cmd_type                 cmd,
   output wasd_pkg::wasd_status_type              status,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic signed [wasd_pkg::MEAN_WIDTH-1:0]   rsp_mean_q4,
   output logic signed [wasd_pkg::CHANGE_WIDTH-1:0] rsp_change_q4,
   output logic [wasd_pkg::LEVEL_WIDTH-1:0]       rsp_level_q12,
   output logic                                   rsp_stable,
   output logic                                   rsp_wiring_error
);

   logic [wasd_pkg::COUNT_WIDTH-1:0]  window_length_ff;
   logic [wasd_pkg::FS_WIDTH-1:0]     full_scale_ff;
   logic [wasd_pkg::THR_WIDTH-1:0]    threshold_ff;
   logic [wasd_pkg::COUNT_WIDTH-1:0]  confirm_ff;

   logic [wasd_pkg::SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [wasd_pkg::COUNT_WIDTH-1:0]  good_ff, good_in;
   logic [wasd_pkg::COUNT_WIDTH-1:0]  index_ff, index_in;
   logic [wasd_pkg::MEAN_WIDTH-1:0]   prev_ff, prev_in;
   logic [wasd_pkg::COUNT_WIDTH-1:0]  settle_ff, settle_in;
   logic [wasd_pkg::MEAN_WIDTH-1:0]   mean_ff, mean_in;
   logic [wasd_pkg::CHANGE_WIDTH-1:0] change_ff, change_in;
   logic [wasd_pkg::LEVEL_WIDTH-1:0]  level_ff, level_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [wasd_pkg::MEAN_WIDTH-1:0]     rsp_mean_ff, rsp_mean_in;
   logic [wasd_pkg::CHANGE_WIDTH-1:0]   rsp_change_ff, rsp_change_in;
   logic [wasd_pkg::LEVEL_WIDTH-1:0]    rsp_level_ff, rsp_level_in;
   logic                                rsp_stable_ff, rsp_stable_in;
   logic                                rsp_wire_ff, rsp_wire_in;

   logic [wasd_pkg::COUNT_WIDTH-1:0]  len_eff;
   logic                              sample_good;
   logic [wasd_pkg::SUM_WIDTH-1:0]    sum_abs;
   logic [wasd_pkg::DIV_WIDTH-1:0]    div_dividend;
   logic [wasd_pkg::DIV_REM_WIDTH-1:0] div_divisor;
   logic                              div_start;
   logic                              div_busy;
   logic                              div_done;
   logic [wasd_pkg::DIV_WIDTH-1:0]    div_quotient;
   logic [wasd_pkg::MEAN_WIDTH-1:0]   q_mean;
   logic [wasd_pkg::CHANGE_WIDTH-1:0] change_abs;
   logic [wasd_pkg::COUNT_WIDTH-1:0]  settle_next;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= wasd_pkg::WINDOW_LENGTH_RESET;
         full_scale_ff    <= wasd_pkg::FULL_SCALE_RESET;
         threshold_ff     <= wasd_pkg::THRESHOLD_RESET;
         confirm_ff       <= wasd_pkg::CONFIRM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            wasd_pkg::CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_data[wasd_pkg::COUNT_WIDTH-1:0];
            end
            wasd_pkg::CSR_FULL_SCALE: begin
               full_scale_ff <= csr_data[wasd_pkg::FS_WIDTH-1:0];
            end
            wasd_pkg::CSR_SETTLE_THRESHOLD: begin
               threshold_ff <= csr_data[wasd_pkg::THR_WIDTH-1:0];
            end
            wasd_pkg::CSR_SETTLE_CONFIRM: begin
               confirm_ff <= csr_data[wasd_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = wasd_pkg::COUNT_WIDTH'(1);
      end else if (window_length_ff > wasd_pkg::MAX_WINDOW) begin
         len_eff = wasd_pkg::MAX_WINDOW;
      end else begin
         len_eff = window_length_ff;
      end
   end

   assign sample_good = req_sample != wasd_pkg::FAILED_READ;

   // divider operands
   assign sum_abs   = sum_ff[wasd_pkg::SUM_WIDTH-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign div_start = cmd.mean_start | cmd.level_start;

   always_comb begin
      if (cmd.mean_start) begin
         div_dividend = {3'b000, sum_abs, 4'b0000};
         div_divisor  = {{(wasd_pkg::DIV_REM_WIDTH-wasd_pkg::COUNT_WIDTH){1'b0}}, good_ff};
      end else begin
         div_dividend = {mean_ff[wasd_pkg::FS_WIDTH-1:0], 12'd0};
         div_divisor  = (full_scale_ff == '0) ? wasd_pkg::FS_WIDTH'(1) : full_scale_ff;
      end
   end

   wasd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign q_mean = div_quotient[wasd_pkg::MEAN_WIDTH-1:0];

   // settle tracking
   assign change_abs = change_ff[wasd_pkg::CHANGE_WIDTH-1] ? (~change_ff + 1'b1) : change_ff;

   always_comb begin
      if (change_abs > {1'b0, threshold_ff}) begin
         settle_next = '0;
      end else if (settle_ff < confirm_ff) begin
         settle_next = settle_ff + 1'b1;
      end else begin
         settle_next = settle_ff;
      end
   end

   always_comb begin
      sum_in    = sum_ff;
      good_in   = good_ff;
      index_in  = index_ff;
      prev_in   = prev_ff;
      settle_in = settle_ff;
      mean_in   = mean_ff;
      change_in = change_ff;
      level_in  = level_ff;

      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_mean_in   = rsp_mean_ff;
      rsp_change_in = rsp_change_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_stable_in = rsp_stable_ff;
      rsp_wire_in   = rsp_wire_ff;

      if (cmd.accept) begin
         if (sample_good) begin
            sum_in  = sum_ff + {{(wasd_pkg::SUM_WIDTH-wasd_pkg::SAMPLE_WIDTH)
                                 {req_sample[wasd_pkg::SAMPLE_WIDTH-1]}}, req_sample};
            good_in = good_ff + 1'b1;
         end
         if (!status.last) begin
            index_in = index_ff + 1'b1;
         end
      end

      if (cmd.mean_latch) begin
         mean_in = sum_ff[wasd_pkg::SUM_WIDTH-1] ? (~q_mean + 1'b1) : q_mean;
      end

      if (cmd.change_latch) begin
         if (prev_ff[wasd_pkg::MEAN_WIDTH-1]) begin
            change_in = '0;
         end else begin
            change_in = {mean_ff[wasd_pkg::MEAN_WIDTH-1], mean_ff}
                      - {prev_ff[wasd_pkg::MEAN_WIDTH-1], prev_ff};
         end
      end

      if (cmd.level_zero) begin
         level_in = '0;
      end else if (cmd.level_latch) begin
         if (div_quotient > {{(wasd_pkg::DIV_WIDTH-wasd_pkg::LEVEL_WIDTH){1'b0}},
                             wasd_pkg::LEVEL_FULL}) begin
            level_in = wasd_pkg::LEVEL_FULL;
         end else begin
            level_in = div_quotient[wasd_pkg::LEVEL_WIDTH-1:0];
         end
      end

      if (cmd.write_result) begin
         rsp_valid_in = 1'b1;
         sum_in       = '0;
         good_in      = '0;
         index_in     = '0;
         if (status.good_zero) begin
            rsp_mean_in   = '0;
            rsp_change_in = '0;
            rsp_level_in  = '0;
            rsp_stable_in = settle_ff >= confirm_ff;
            rsp_wire_in   = 1'b1;
         end else begin
            rsp_mean_in   = mean_ff;
            rsp_change_in = change_ff;
            rsp_level_in  = level_ff;
            rsp_stable_in = settle_next >= confirm_ff;
            rsp_wire_in   = 1'b0;
            prev_in       = mean_ff;
            settle_in     = settle_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         good_ff      <= '0;
         index_ff     <= '0;
         prev_ff      <= wasd_pkg::MEAN_SENTINEL;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         good_ff      <= good_in;
         index_ff     <= index_in;
         prev_ff      <= prev_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff       <= mean_in;
      change_ff     <= change_in;
      level_ff      <= level_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_change_ff <= rsp_change_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_stable_ff <= rsp_stable_in;
      rsp_wire_ff   <= rsp_wire_in;
   end

   assign status.last        = ({1'b0, index_ff} + 1'b1) >= {1'b0, len_eff};
   assign status.good_zero   = good_ff == '0;
   assign status.mean_nonpos = mean_ff[wasd_pkg::MEAN_WIDTH-1] | (mean_ff == '0);
   assign status.div_done    = div_done;
   assign status.out_free    = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_q4      = rsp_mean_ff;
   assign rsp_change_q4    = rsp_change_ff;
   assign rsp_level_q12    = rsp_level_ff;
   assign rsp_stable       = rsp_stable_ff;
   assign rsp_wiring_error = rsp_wire_ff;

   // no sample taken while a division runs
   assert property (@(posedge clock) disable iff (reset) cmd.accept |-> !div_busy)
      else $error("sample accepted during division");

   // window restarts after each result
   assert property (@(posedge clock) disable iff (reset)
      cmd.write_result |=> (good_ff == '0) && (index_ff == '0) && (sum_ff == '0))
      else $error("window not cleared after result");

   // a wiring error result carries no figures
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wire_ff) |-> (rsp_mean_ff == '0) && (rsp_level_ff == '0))
      else $error("wiring error result with figures");

   // level never beyond full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= wasd_pkg::LEVEL_FULL))
      else $error("level out of range");

endmodule

### rtl/wasd_ctrl.sv
// sequencer for accumulation, the two divisions and result hand-off
`timescale 1ns / 1ps

module wasd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  wasd_pkg::wasd_status_type  status,
   output wasd_pkg::wasd_cmd_type     cmd
);

   wasd_pkg::wasd_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wasd_pkg::ST_ACCUM: begin
            if (req_valid && status.last) begin
               state_in = wasd_pkg::ST_MEAN_START;
            end
         end
         wasd_pkg::ST_MEAN_START: begin
            state_in = status.good_zero ? wasd_pkg::ST_RESULT : wasd_pkg::ST_MEAN_RUN;
         end
         wasd_pkg::ST_MEAN_RUN: begin
            if (status.div_done) begin
               state_in = wasd_pkg::ST_LEVEL_START;
            end
         end
         wasd_pkg::ST_LEVEL_START: begin
            state_in = status.mean_nonpos ? wasd_pkg::ST_RESULT : wasd_pkg::ST_LEVEL_RUN;
         end
         wasd_pkg::ST_LEVEL_RUN: begin
            if (status.div_done) begin
               state_in = wasd_pkg::ST_RESULT;
            end
         end
         wasd_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = wasd_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = wasd_pkg::ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         wasd_pkg::ST_ACCUM: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         wasd_pkg::ST_MEAN_START: begin
            cmd.mean_start = ~status.good_zero;
         end
         wasd_pkg::ST_MEAN_RUN: begin
            cmd.mean_latch = status.div_done;
         end
         wasd_pkg::ST_LEVEL_START: begin
            cmd.change_latch = 1'b1;
            cmd.level_zero   = status.mean_nonpos;
            cmd.level_start  = ~status.mean_nonpos;
         end
         wasd_pkg::ST_LEVEL_RUN: begin
            cmd.level_latch = status.div_done;
         end
         wasd_pkg::ST_RESULT: begin
            cmd.write_result = status.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wasd_pkg::ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/window_average_settle_detect.sv
// top level: window average with settle detection
// a sample that does not close the window is taken without a stall, back to back
// the closing sample holds req_stall high for two 31-step serial divisions in
// one shared divider, only the mean division for a mean of zero or below, none
// for a window with no valid sample, longer while the result register is stalled
// synchronous reset clears the window, settle count and result valid, sets
// the previous mean to -1.0 and loads the register defaults
`timescale 1ns / 1ps

module window_average_settle_detect (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [wasd_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [wasd_pkg::MEAN_WIDTH-1:0]   rsp_mean_q4,
   output logic signed [wasd_pkg::CHANGE_WIDTH-1:0] rsp_change_q4,
   output logic [wasd_pkg::LEVEL_WIDTH-1:0]         rsp_level_q12,
   output logic                                     rsp_stable,
   output logic                                     rsp_wiring_error,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [wasd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [wasd_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   wasd_pkg::wasd_cmd_type    cmd;
   wasd_pkg::wasd_status_type status;

   assign csr_ready = 1'b1;

   wasd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wasd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_sample       (req_sample),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_mean_q4      (rsp_mean_q4),
      .rsp_change_q4    (rsp_change_q4),
      .rsp_level_q12    (rsp_level_q12),
      .rsp_stable       (rsp_stable),
      .rsp_wiring_error (rsp_wiring_error)
   );

endmodule
